[hdl/rcm_pkg.sv]
// shared constants, types and arithmetic helpers for the rgb color matrix
package rcm_pkg;

    localparam int PIXEL_W     = 32;
    localparam int CHAN_W      = 8;
    localparam int COEF_W      = 16;
    localparam int NUM_COEF    = 4;
    localparam int ROW_W       = COEF_W * NUM_COEF;
    localparam int MODE_W      = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = ROW_W;

    // fixed-point one of the coefficients, a power of two
    localparam int COEF_ONE   = 1024;
    localparam int COEF_SHIFT = $clog2(COEF_ONE);

    // unsigned channel value times signed coefficient, then four terms summed
    localparam int PROD_W = CHAN_W + 1 + COEF_W;
    localparam int SUM_W  = PROD_W + $clog2(NUM_COEF);

    localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = CHAN_MAX;

    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(COEF_ONE - 1);
    localparam logic signed [SUM_W-1:0] SAT_LIMIT  = SUM_W'(CHAN_MAX);

    localparam logic [MODE_W-1:0] MODE_IDENTITY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BRIGHT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MATRIX   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_RED   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_GREEN = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_BLUE  = 2'd3;

    typedef enum logic [1:0] {
        CHAN_RED   = 2'd0,
        CHAN_GREEN = 2'd1,
        CHAN_BLUE  = 2'd2
    } chan_t;

    typedef struct packed {
        logic en2;
        logic en3;
    } stage_ctl_t;

    function automatic logic signed [COEF_W-1:0] coef(logic [ROW_W-1:0] row,
                                                      logic [1:0] k);
        return $signed(row[COEF_W*k +: COEF_W]);
    endfunction

    // divide by the fixed-point one, truncating toward zero
    function automatic logic signed [SUM_W-1:0] div_one(logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] adj;
        adj = s[SUM_W-1] ? (s + ROUND_BIAS) : s;
        return adj >>> COEF_SHIFT;
    endfunction

endpackage

[hdl/rcm_stream_if.sv]
// stream interfaces for input and result pixel words
interface rcm_in_if;
    logic                        valid;
    logic                        ready;
    logic [rcm_pkg::PIXEL_W-1:0] pixel_in;
    logic                        last_in;

    modport source (output valid, output pixel_in, output last_in, input ready);
    modport sink   (input valid, input pixel_in, input last_in, output ready);
endinterface

interface rcm_out_if;
    logic                        valid;
    logic                        ready;
    logic [rcm_pkg::PIXEL_W-1:0] pixel_out;
    logic                        last_out;

    modport source (output valid, output pixel_out, output last_out, input ready);
    modport sink   (input valid, input pixel_out, input last_out, output ready);
endinterface

[hdl/rgb_color_matrix.sv]
// top level of the rgb color matrix pixel transform
//
//  port      dir   width        contents
//  pixels    sink  32 + 1       pixel_in, last_in under valid/ready
//  results   src   32 + 1       pixel_out, last_out under valid/ready
//  cfg_*     in    1 + 2 + 64   write enable, register index, write data
//
// one word per clock sustained while the results side is ready
// stages: input register, product register (four 9x16 multipliers per channel),
// result register after sum, scaling and clamp
// a stalled result holds the last stage and every full stage before it; earlier empty stages keep filling
// rst_n clears the stage valids and all configuration registers
module rgb_color_matrix (
    input  logic                            clk,
    input  logic                            rst_n,
    rcm_in_if.sink                          pixels,
    rcm_out_if.source                       results,
    input  logic                            cfg_we,
    input  logic [rcm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rcm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [rcm_pkg::MODE_W-1:0]  mode_reg;
    logic [rcm_pkg::ROW_W-1:0]   row_red_reg;
    logic [rcm_pkg::ROW_W-1:0]   row_green_reg;
    logic [rcm_pkg::ROW_W-1:0]   row_blue_reg;

    logic                        v1_reg, v2_reg, v3_reg;
    logic [rcm_pkg::PIXEL_W-1:0] pix1_reg, pix2_reg, pix3_reg;
    logic                        last1_reg, last2_reg, last3_reg;
    logic                        en1, en2, en3;
    rcm_pkg::stage_ctl_t         ctl;

    logic [rcm_pkg::CHAN_W-1:0]  red1, green1, blue1;
    logic [rcm_pkg::CHAN_W-1:0]  red3_reg, green3_reg, blue3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= rcm_pkg::MODE_IDENTITY;
            row_red_reg   <= '0;
            row_green_reg <= '0;
            row_blue_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rcm_pkg::CFG_MODE:      mode_reg      <= cfg_data[rcm_pkg::MODE_W-1:0];
                rcm_pkg::CFG_ROW_RED:   row_red_reg   <= cfg_data;
                rcm_pkg::CFG_ROW_GREEN: row_green_reg <= cfg_data;
                rcm_pkg::CFG_ROW_BLUE:  row_blue_reg  <= cfg_data;
                default:                ;
            endcase
        end
    end

    // a stage loads when it is empty or its word moves on
    assign en3 = !v3_reg || results.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign pixels.ready = en1;

    assign ctl.en2 = en2;
    assign ctl.en3 = en3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= pixels.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            pix1_reg  <= pixels.pixel_in;
            last1_reg <= pixels.last_in;
        end
        if (en2)
        begin
            pix2_reg  <= pix1_reg;
            last2_reg <= last1_reg;
        end
        if (en3)
        begin
            pix3_reg  <= pix2_reg;
            last3_reg <= last2_reg;
        end
    end

    assign red1   = pix1_reg[rcm_pkg::CHAN_W-1:0];
    assign green1 = pix1_reg[2*rcm_pkg::CHAN_W-1:rcm_pkg::CHAN_W];
    assign blue1  = pix1_reg[3*rcm_pkg::CHAN_W-1:2*rcm_pkg::CHAN_W];

    rcm_channel u_red (
        .clk       (clk),
        .ctl       (ctl),
        .mode      (mode_reg),
        .diag      (rcm_pkg::CHAN_RED),
        .row       (row_red_reg),
        .red       (red1),
        .green     (green1),
        .blue      (blue1),
        .value_reg (red3_reg)
    );

    rcm_channel u_green (
        .clk       (clk),
        .ctl       (ctl),
        .mode      (mode_reg),
        .diag      (rcm_pkg::CHAN_GREEN),
        .row       (row_green_reg),
        .red       (red1),
        .green     (green1),
        .blue      (blue1),
        .value_reg (green3_reg)
    );

    rcm_channel u_blue (
        .clk       (clk),
        .ctl       (ctl),
        .mode      (mode_reg),
        .diag      (rcm_pkg::CHAN_BLUE),
        .row       (row_blue_reg),
        .red       (red1),
        .green     (green1),
        .blue      (blue1),
        .value_reg (blue3_reg)
    );

    assign results.valid     = v3_reg;
    assign results.last_out  = last3_reg;
    assign results.pixel_out = (mode_reg == rcm_pkg::MODE_IDENTITY) ? pix3_reg
                             : {rcm_pkg::ALPHA_OPAQUE, blue3_reg, green3_reg, red3_reg};

`ifndef SYNTHESIS
    // transformed words always leave opaque
    a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && mode_reg != rcm_pkg::MODE_IDENTITY)
        |-> results.pixel_out[rcm_pkg::PIXEL_W-1:3*rcm_pkg::CHAN_W] == rcm_pkg::ALPHA_OPAQUE)
        else $error("alpha not forced in transform mode");

    // an empty input stage never refuses a word
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> pixels.ready)
        else $error("input refused with empty first stage");

    // a blocked first stage keeps its word
    a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !en2) |=> (v1_reg && $stable(pix1_reg)))
        else $error("first stage word lost under stall");

    // a word in the middle stage moves on only into a free last stage
    a_stage2_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && en3) |=> v3_reg)
        else $error("middle stage word dropped");
`endif

endmodule

[hdl/rcm_channel.sv]
// one output channel: registered products, then sum, scale and clamp, or in brightness mode the scaled diagonal product
module rcm_channel (
    input  logic                        clk,
    input  rcm_pkg::stage_ctl_t         ctl,
    input  logic [rcm_pkg::MODE_W-1:0]  mode,
    input  rcm_pkg::chan_t              diag,
    input  logic [rcm_pkg::ROW_W-1:0]   row,
    input  logic [rcm_pkg::CHAN_W-1:0]  red,
    input  logic [rcm_pkg::CHAN_W-1:0]  green,
    input  logic [rcm_pkg::CHAN_W-1:0]  blue,
    output logic [rcm_pkg::CHAN_W-1:0]  value_reg
);

    logic [rcm_pkg::CHAN_W-1:0]        comp [rcm_pkg::NUM_COEF];
    logic signed [rcm_pkg::PROD_W-1:0] prod_next [rcm_pkg::NUM_COEF];
    logic signed [rcm_pkg::PROD_W-1:0] prod_reg [rcm_pkg::NUM_COEF];
    logic signed [rcm_pkg::PROD_W-1:0] diag_prod;
    logic signed [rcm_pkg::SUM_W-1:0]  sum;
    logic signed [rcm_pkg::SUM_W-1:0]  bright_q;
    logic signed [rcm_pkg::SUM_W-1:0]  matrix_q;
    logic [rcm_pkg::CHAN_W-1:0]        bright_val;
    logic [rcm_pkg::CHAN_W-1:0]        matrix_val;
    logic [rcm_pkg::CHAN_W-1:0]        value_next;

    assign comp[0] = red;
    assign comp[1] = green;
    assign comp[2] = blue;
    // offset term multiplies a constant full-scale value, not the input alpha
    assign comp[3] = rcm_pkg::CHAN_MAX;

    for (genvar k = 0; k < rcm_pkg::NUM_COEF; k++) begin : g_prod
        assign prod_next[k] = $signed({1'b0, comp[k]}) * rcm_pkg::coef(row, 2'(k));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en2)
        begin
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        case (diag)
            rcm_pkg::CHAN_RED:   diag_prod = prod_reg[0];
            rcm_pkg::CHAN_GREEN: diag_prod = prod_reg[1];
            default:             diag_prod = prod_reg[2];
        endcase
    end

    assign sum = rcm_pkg::SUM_W'(prod_reg[0]) + rcm_pkg::SUM_W'(prod_reg[1])
               + rcm_pkg::SUM_W'(prod_reg[2]) + rcm_pkg::SUM_W'(prod_reg[3]);

    assign bright_q = rcm_pkg::div_one(rcm_pkg::SUM_W'(diag_prod));
    assign matrix_q = rcm_pkg::div_one(sum);

    // brightness saturates only upward, a negative value keeps its low byte
    assign bright_val = (bright_q > rcm_pkg::SAT_LIMIT) ? rcm_pkg::CHAN_MAX
                                                        : bright_q[rcm_pkg::CHAN_W-1:0];

    always_comb
    begin
        if (matrix_q[rcm_pkg::SUM_W-1])
        begin
            matrix_val = '0;
        end
        else if (matrix_q > rcm_pkg::SAT_LIMIT)
        begin
            matrix_val = rcm_pkg::CHAN_MAX;
        end
        else
        begin
            matrix_val = matrix_q[rcm_pkg::CHAN_W-1:0];
        end
    end

    always_comb
    begin
        case (mode)
            rcm_pkg::MODE_BRIGHT: value_next = bright_val;
            default:              value_next = matrix_val;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en3)
        begin
            value_reg <= value_next;
        end
    end

endmodule
